### rtl/lrfc_pkg.sv
// Shared types, constants and codes for the lock reply frame checker.
package lrfc_pkg;

  localparam int unsigned MAX_LOCKS = 16;
  localparam int unsigned LIDX_W = (MAX_LOCKS > 1) ? $clog2(MAX_LOCKS) : 1;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CODE_W = 3;
  localparam int unsigned LOCK_INDEX_W = 4;
  localparam int unsigned LOCK_COUNT_W = 5;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 8;

  // Frame header bytes at offsets zero to three.
  localparam logic [BYTE_W-1:0] HDR_BYTES [4] = '{8'h57, 8'h4B, 8'h4C, 8'h59};

  // Fixed offsets within a frame.
  localparam logic [BYTE_W-1:0] OFS_LEN     = 8'd4;
  localparam logic [BYTE_W-1:0] OFS_ADDR    = 8'd5;
  localparam logic [BYTE_W-1:0] OFS_CMD     = 8'd6;
  localparam logic [BYTE_W-1:0] OFS_OPSTAT  = 8'd7;
  localparam logic [BYTE_W-1:0] OFS_EIGHT   = 8'd8;
  localparam logic [BYTE_W-1:0] OFS_NINE    = 8'd9;
  localparam logic [BYTE_W-1:0] OFS_STATUS  = 8'd9;
  localparam logic [BYTE_W-1:0] HDR_LEN     = 8'd4;
  localparam logic [BYTE_W-1:0] COUNT_MAX   = 8'd255;

  typedef enum logic [CODE_W-1:0] {
    RES_OK      = 3'd0,
    RES_PARAM   = 3'd1,
    RES_HEADER  = 3'd2,
    RES_LENGTH  = 3'd3,
    RES_XOR     = 3'd4,
    RES_COMMAND = 3'd5
  } res_code_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_REPLY_LEN     = 3'd0,
    CFG_SINGLE_REPLY_LEN  = 3'd1,
    CFG_READ_ALL_OVERHEAD = 3'd2,
    CFG_READ_ALL_COMMAND  = 3'd3,
    CFG_STATUS_LIMIT      = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
    logic              kind;
    logic [BYTE_W-1:0] expected_command;
  } in_word_t;

  typedef struct packed {
    logic [CODE_W-1:0]       result_code;
    logic [BYTE_W-1:0]       src_address;
    logic [BYTE_W-1:0]       command_code;
    logic [BYTE_W-1:0]       oper_status;
    logic [BYTE_W-1:0]       channel;
    logic [BYTE_W-1:0]       single_lock_state;
    logic [LOCK_INDEX_W-1:0] lock_index;
    logic [BYTE_W-1:0]       status_byte;
    logic [LOCK_COUNT_W-1:0] lock_count;
    logic                    last_result;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              take_byte;
    logic              latch_result;
    logic              clear_frame;
    logic [LIDX_W-1:0] rd_idx;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic multi;     // evaluation gives one word per lock
    logic out_last;  // word now presented is the last of the frame
  } dp_status_t;

endpackage

### rtl/lrfc_dp.sv
// Datapath: frame capture, status store, configuration and final checks.
module lrfc_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lrfc_pkg::in_word_t          in_word_i,
  input  logic                        cfg_we_i,
  input  logic [lrfc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [lrfc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  lrfc_pkg::dp_cmd_t           cmd_i,
  output lrfc_pkg::dp_status_t        status_o,
  output lrfc_pkg::out_word_t         out_word_o
);
  import lrfc_pkg::*;

  typedef enum logic [1:0] {MODE_CODE, MODE_GEN, MODE_RA} res_mode_e;

  // Configuration registers.
  logic [BYTE_W-1:0]       min_len_q, single_len_q, ra_ovh_q, ra_cmd_q;
  logic [LOCK_COUNT_W-1:0] limit_q;

  // Per-frame state.
  logic [BYTE_W-1:0] byte_count_q, byte_count_d;
  logic              too_long_q, too_long_d;
  logic [BYTE_W-1:0] xor_q, xor_d;
  logic              hdr_ok_q, hdr_ok_d;
  logic [BYTE_W-1:0] len_field_q, len_field_d;
  logic [BYTE_W-1:0] addr_q, addr_d, cmd_q, cmd_d, opstat_q, opstat_d;
  logic [BYTE_W-1:0] eight_q, eight_d, nine_q, nine_d;
  logic              kind_q;
  logic [BYTE_W-1:0] expect_q;

  // Result registers.
  res_code_e res_code_q, res_code_d;
  res_mode_e res_mode_q, res_mode_d;

  // Status store.
  logic [BYTE_W-1:0] store_mem [MAX_LOCKS];
  logic [BYTE_W-1:0] rd_q;
  logic [BYTE_W-1:0] wr_ofs;
  logic              wr_hit;

  logic [BYTE_W-1:0] pos, b;
  logic [8:0]        ra_min, ra_total;
  logic [BYTE_W-1:0] lim, want_cmd;
  logic [BYTE_W-1:0] idx_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q    <= 8'd9;
      single_len_q <= 8'd11;
      ra_ovh_q     <= 8'd10;
      ra_cmd_q     <= 8'd0;
      limit_q      <= 5'd16;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_MIN_REPLY_LEN:     min_len_q    <= cfg_wdata_i;
        CFG_SINGLE_REPLY_LEN:  single_len_q <= cfg_wdata_i;
        CFG_READ_ALL_OVERHEAD: ra_ovh_q     <= cfg_wdata_i;
        CFG_READ_ALL_COMMAND:  ra_cmd_q     <= cfg_wdata_i;
        CFG_STATUS_LIMIT:      limit_q      <= cfg_wdata_i[LOCK_COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign pos    = byte_count_q;
  assign b      = in_word_i.data_byte;
  assign wr_ofs = pos - OFS_STATUS;
  assign wr_hit = (pos >= OFS_STATUS) && (wr_ofs < BYTE_W'(MAX_LOCKS));

  always_comb begin
    byte_count_d = byte_count_q;
    too_long_d   = too_long_q;
    xor_d        = xor_q ^ b;
    hdr_ok_d     = hdr_ok_q;
    len_field_d  = len_field_q;
    addr_d       = addr_q;
    cmd_d        = cmd_q;
    opstat_d     = opstat_q;
    eight_d      = eight_q;
    nine_d       = nine_q;
    if (!too_long_q) begin
      if (pos < HDR_LEN && b != HDR_BYTES[pos[1:0]]) hdr_ok_d = 1'b0;
      if (pos == OFS_LEN)    len_field_d = b;
      if (pos == OFS_ADDR)   addr_d      = b;
      if (pos == OFS_CMD)    cmd_d       = b;
      if (pos == OFS_OPSTAT) opstat_d    = b;
      if (pos == OFS_EIGHT)  eight_d     = b;
      if (pos == OFS_NINE)   nine_d      = b;
      if (pos == COUNT_MAX) too_long_d   = 1'b1;
      else                  byte_count_d = pos + 8'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q <= '0;
      too_long_q   <= 1'b0;
      xor_q        <= '0;
      hdr_ok_q     <= 1'b1;
      len_field_q  <= '0;
      addr_q       <= '0;
      cmd_q        <= '0;
      opstat_q     <= '0;
      eight_q      <= '0;
      nine_q       <= '0;
    end else if (cmd_i.clear_frame) begin
      byte_count_q <= '0;
      too_long_q   <= 1'b0;
      xor_q        <= '0;
      hdr_ok_q     <= 1'b1;
      len_field_q  <= '0;
      addr_q       <= '0;
      cmd_q        <= '0;
      opstat_q     <= '0;
      eight_q      <= '0;
      nine_q       <= '0;
    end else if (cmd_i.take_byte) begin
      byte_count_q <= byte_count_d;
      too_long_q   <= too_long_d;
      xor_q        <= xor_d;
      hdr_ok_q     <= hdr_ok_d;
      len_field_q  <= len_field_d;
      addr_q       <= addr_d;
      cmd_q        <= cmd_d;
      opstat_q     <= opstat_d;
      eight_q      <= eight_d;
      nine_q       <= nine_d;
    end
  end

  // The mode and expected command only matter at the last byte.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_byte && in_word_i.last_byte) begin
      kind_q   <= in_word_i.kind;
      expect_q <= in_word_i.expected_command;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_byte && !too_long_q && wr_hit) begin
      store_mem[wr_ofs[LIDX_W-1:0]] <= b;
    end
    rd_q <= store_mem[cmd_i.rd_idx];
  end

  // Final checks, in priority order, on the captured frame.
  assign ra_min   = {1'b0, ra_ovh_q} + 9'd1;
  assign ra_total = {1'b0, ra_ovh_q} + {1'b0, eight_q};
  assign lim      = (limit_q > LOCK_COUNT_W'(MAX_LOCKS)) ? BYTE_W'(MAX_LOCKS)
                                                         : BYTE_W'(limit_q);
  assign want_cmd = kind_q ? ra_cmd_q : expect_q;

  always_comb begin
    res_code_d = RES_OK;
    res_mode_d = MODE_CODE;
    priority if (!kind_q && byte_count_q < min_len_q) begin
      res_code_d = RES_PARAM;
    end else if (kind_q && {1'b0, byte_count_q} < ra_min) begin
      res_code_d = RES_PARAM;
    end else if (byte_count_q < HDR_LEN || !hdr_ok_q) begin
      res_code_d = RES_HEADER;
    end else if (too_long_q || len_field_q != byte_count_q) begin
      res_code_d = RES_LENGTH;
    end else if (xor_q != '0) begin
      res_code_d = RES_XOR;
    end else if (cmd_q != want_cmd) begin
      res_code_d = RES_COMMAND;
    end else if (!kind_q) begin
      res_mode_d = MODE_GEN;
    end else if (ra_total != {1'b0, byte_count_q}) begin
      res_code_d = RES_LENGTH;
    end else if (eight_q > lim) begin
      res_code_d = RES_PARAM;
    end else if (eight_q != '0) begin
      res_mode_d = MODE_RA;
    end else begin
      res_mode_d = MODE_CODE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_code_q <= RES_OK;
      res_mode_q <= MODE_CODE;
    end else if (cmd_i.latch_result) begin
      res_code_q <= res_code_d;
      res_mode_q <= res_mode_d;
    end
  end

  assign idx_ext = BYTE_W'(cmd_i.rd_idx);

  assign status_o.multi    = (res_mode_d == MODE_RA);
  assign status_o.out_last = (res_mode_q != MODE_RA) || (idx_ext + 8'd1 == eight_q);

  always_comb begin
    out_word_o             = '0;
    out_word_o.result_code = res_code_q;
    out_word_o.last_result = status_o.out_last;
    unique case (res_mode_q)
      MODE_GEN: begin
        out_word_o.src_address  = addr_q;
        out_word_o.command_code = cmd_q;
        out_word_o.oper_status  = opstat_q;
        if (byte_count_q >= single_len_q) begin
          out_word_o.channel           = eight_q;
          out_word_o.single_lock_state = nine_q;
        end
      end
      MODE_RA: begin
        out_word_o.lock_index  = LOCK_INDEX_W'(cmd_i.rd_idx);
        out_word_o.lock_count  = eight_q[LOCK_COUNT_W-1:0];
        out_word_o.status_byte = (idx_ext + OFS_STATUS < byte_count_q) ? rd_q : '0;
      end
      default: ;
    endcase
  end

endmodule

### rtl/lrfc_ctrl.sv
// Controller: sequences byte intake, evaluation and delivery of result words.
module lrfc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_last_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  lrfc_pkg::dp_status_t status_i,
  output lrfc_pkg::dp_cmd_t    cmd_o
);
  import lrfc_pkg::*;

  typedef enum logic [1:0] {ST_COLLECT, ST_EVAL, ST_READ, ST_SHOW} state_e;

  state_e            state_q;
  logic              out_valid_q;
  logic [LIDX_W-1:0] idx_q;
  logic              in_take, out_take;

  assign in_take  = (state_q == ST_COLLECT) && in_valid_i;
  assign out_take = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_COLLECT;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      unique case (state_q)
        ST_COLLECT: begin
          if (in_take && in_last_i) state_q <= ST_EVAL;
        end
        ST_EVAL: begin
          idx_q <= '0;
          if (status_i.multi) begin
            state_q <= ST_READ;
          end else begin
            state_q     <= ST_SHOW;
            out_valid_q <= 1'b1;
          end
        end
        ST_READ: begin
          state_q     <= ST_SHOW;
          out_valid_q <= 1'b1;
        end
        ST_SHOW: begin
          if (out_take) begin
            out_valid_q <= 1'b0;
            if (status_i.out_last) begin
              state_q <= ST_COLLECT;
            end else begin
              idx_q   <= idx_q + 1'b1;
              state_q <= ST_READ;
            end
          end
        end
        default: state_q <= ST_COLLECT;
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_COLLECT);
  assign out_valid_o = out_valid_q;

  assign cmd_o.take_byte    = in_take;
  assign cmd_o.latch_result = (state_q == ST_EVAL);
  assign cmd_o.clear_frame  = (state_q == ST_SHOW) && out_take && status_i.out_last;
  assign cmd_o.rd_idx       = idx_q;

endmodule

### rtl/lock_reply_frame_checker_top.sv
// Top level of the lock reply frame checker: controller plus datapath.
//
//   channel   direction  handshake             word
//   in        input      in_valid_i/in_stall_o   lrfc_pkg::in_word_t
//   out       output     out_valid_o/out_stall_i lrfc_pkg::out_word_t
//   cfg       input      cfg_we_i (no wait)      cfg_index_i, cfg_wdata_i
//
// Bytes that are not the last of a frame are taken one per cycle, with no
// stall. The last byte is followed by an evaluation state; a generic reply
// or an error then presents its single word. A read-all reply with N locks
// presents N words, each read from the status store in a read state and
// then held in a show state until it is taken. The input stalls from the
// last byte until the last word of the frame has been taken.
// Reset is asynchronous and active low; it restores the register defaults
// and clears the frame state. The status store needs no clearing, since
// only entries written in the current frame are read.
module lock_reply_frame_checker_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  lrfc_pkg::in_word_t              in_word_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output lrfc_pkg::out_word_t             out_word_o,
  input  logic                            cfg_we_i,
  input  logic [lrfc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [lrfc_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import lrfc_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  // The controller owns both handshakes and the lock index counter.
  lrfc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_last_i   (in_word_i.last_byte),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (dp_status),
    .cmd_o       (dp_cmd)
  );

  // The datapath holds the captured frame, the status store, the
  // configuration registers and the result, and forms the output word.
  lrfc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (dp_cmd),
    .status_o    (dp_status),
    .out_word_o  (out_word_o)
  );

endmodule
